// ----- src/three_point_curvature_classifier_core_defines.svh -----
`ifndef THREE_POINT_CURVATURE_CLASSIFIER_CORE_DEFINES_SVH
`define THREE_POINT_CURVATURE_CLASSIFIER_CORE_DEFINES_SVH

// Implication checked outside reset.
`define TPCC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpcc check failed");

// Next-cycle implication, also checked across reset.
`define TPCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tpcc check failed");

`endif

// ----- src/tpcc_pkg.sv -----
`default_nettype none
package tpcc_pkg;
    localparam int CURV_BITS = 26;
    localparam logic [CURV_BITS-1:0] CURV_MAX = {CURV_BITS{1'b1}};
    localparam logic [CURV_BITS-1:0] THRESH_RESET = 26'd83886;

    typedef struct packed {
        logic valid;
        logic zero;
        logic sat;
    } t_ctl;
endpackage
`default_nettype wire

// ----- src/tpcc_sqrt_cell.sv -----
`default_nettype none
module tpcc_sqrt_cell #(
    parameter int SQW = 35,
    parameter int RW  = 18,
    parameter int TAGW = 35,
    parameter int K   = 0
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  tpcc_pkg::t_ctl              i_ctl,
    input  wire [2:0][SQW-1:0]          i_rem,
    input  wire [2:0][RW-1:0]           i_root,
    input  wire [TAGW-1:0]              i_tag,
    output tpcc_pkg::t_ctl              o_ctl,
    output logic [2:0][SQW-1:0]         o_rem,
    output logic [2:0][RW-1:0]          o_root,
    output logic [TAGW-1:0]             o_tag
);
    localparam int TW = SQW + RW + 2;

    tpcc_pkg::t_ctl       r_ctl;
    logic [2:0][SQW-1:0]  r_rem, n_rem;
    logic [2:0][RW-1:0]   r_root, n_root;
    logic [TAGW-1:0]      r_tag;

    // One root bit per lane: try 2*r*2^K + 2^2K against the remainder.
    always_comb begin
        logic [TW-1:0] trial;
        logic [TW-1:0] remx;
        for (int l = 0; l < 3; l++) begin
            remx  = {{(TW-SQW){1'b0}}, i_rem[l]};
            trial = ({{(TW-RW){1'b0}}, i_root[l]} << (K + 1))
                  | ({{(TW-1){1'b0}}, 1'b1} << (2 * K));
            if (remx >= trial) begin
                n_rem[l]  = SQW'(remx - trial);
                n_root[l] = i_root[l] | ({{(RW-1){1'b0}}, 1'b1} << K);
            end else begin
                n_rem[l]  = i_rem[l];
                n_root[l] = i_root[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_tag  <= i_tag;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_tag  = r_tag;
endmodule
`default_nettype wire

// ----- src/tpcc_div_cell.sv -----
`default_nettype none
module tpcc_div_cell #(
    parameter int XW   = 77,
    parameter int DENW = 54,
    parameter int IDX  = 0
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tpcc_pkg::t_ctl                     i_ctl,
    input  wire [XW-1:0]                       i_rem,
    input  wire [tpcc_pkg::CURV_BITS-1:0]      i_quo,
    input  wire [DENW-1:0]                     i_den,
    output tpcc_pkg::t_ctl                     o_ctl,
    output logic [XW-1:0]                      o_rem,
    output logic [tpcc_pkg::CURV_BITS-1:0]     o_quo,
    output logic [DENW-1:0]                    o_den
);
    tpcc_pkg::t_ctl                   r_ctl;
    logic [XW-1:0]                    r_rem, n_rem;
    logic [tpcc_pkg::CURV_BITS-1:0]   r_quo, n_quo;
    logic [DENW-1:0]                  r_den;
    logic [XW-1:0]                    trial;

    assign trial = {{(XW-DENW){1'b0}}, i_den} << IDX;

    always_comb begin
        if (i_rem >= trial) begin
            n_rem = i_rem - trial;
            n_quo = i_quo | ({{(tpcc_pkg::CURV_BITS-1){1'b0}}, 1'b1} << IDX);
        end else begin
            n_rem = i_rem;
            n_quo = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= i_den;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;
endmodule
`default_nettype wire

// ----- src/three_point_curvature_classifier_core.sv -----
`default_nettype none
// Throughput: one item per cycle; o_busy is always low.
// Timing is set by the chain of square-root cells (one root bit each) and the
// chain of 26 divider cells (one quotient bit each).
// Each result shows for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset flushes the pipeline and reloads the threshold.
module three_point_curvature_classifier_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 24
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    output logic                              o_busy,
    input  wire                               i_has_three_points,
    input  wire signed [COORD_BITS-1:0]       i_start_x,
    input  wire signed [COORD_BITS-1:0]       i_start_y,
    input  wire signed [COORD_BITS-1:0]       i_mid_x,
    input  wire signed [COORD_BITS-1:0]       i_mid_y,
    input  wire signed [COORD_BITS-1:0]       i_end_x,
    input  wire signed [COORD_BITS-1:0]       i_end_y,
    input  wire                               i_cfg_we,
    input  wire [tpcc_pkg::CURV_BITS-1:0]     i_cfg_data,
    output logic                              o_valid,
    output logic [tpcc_pkg::CURV_BITS-1:0]    o_curvature,
    output logic                              o_is_arch
);
    localparam int CB   = tpcc_pkg::CURV_BITS;
    localparam int D    = COORD_BITS + 1;
    localparam int SQW  = 2 * D + 1;
    localparam int RW   = D + 1;
    localparam int DENW = 3 * RW;
    localparam int NUMW = SQW + FRAC_BITS + 1;
    localparam int XW   = (NUMW > DENW + CB) ? NUMW : DENW + CB;
    localparam int LAT_CYCLES = 7 + RW + CB;

    logic [CB-1:0] r_thr;

    // stage 1: differences
    tpcc_pkg::t_ctl          r1_ctl;
    logic signed [D-1:0]     r1_ux, r1_uy, r1_vx, r1_vy, r1_wx, r1_wy;
    // stage 2: products
    tpcc_pkg::t_ctl          r2_ctl;
    logic signed [2*D-1:0]   r2_p1, r2_p2;
    logic signed [2*D-1:0]   n2_p1, n2_p2;
    logic signed [2*D-1:0]   n2_s0, n2_s1, n2_s2, n2_s3, n2_s4, n2_s5;
    logic [5:0][2*D-1:0]     r2_sq;
    // stage 3: cross magnitude and squared sides
    tpcc_pkg::t_ctl          r3_ctl;
    logic [SQW-1:0]          r3_cross;
    logic [2:0][SQW-1:0]     r3_sq;
    logic signed [SQW-1:0]   n3_cross;

    tpcc_pkg::t_ctl          s_ctl  [0:RW];
    logic [2:0][SQW-1:0]     s_rem  [0:RW];
    logic [2:0][RW-1:0]      s_root [0:RW];
    logic [SQW-1:0]          s_tag  [0:RW];

    tpcc_pkg::t_ctl          r4_ctl, r5_ctl, r6_ctl;
    logic [2*RW-1:0]         r4_ab;
    logic [RW-1:0]           r4_c;
    logic [SQW-1:0]          r4_cross, r5_cross;
    logic [DENW-1:0]         r5_den, r6_den;
    logic [XW-1:0]           r6_num;
    logic [XW-1:0]           n6_num;

    tpcc_pkg::t_ctl          d_ctl [0:CB];
    logic [XW-1:0]           d_rem [0:CB];
    logic [CB-1:0]           d_quo [0:CB];
    logic [DENW-1:0]         d_den [0:CB];

    logic                    r_valid;
    logic [CB-1:0]           r_curv, n_curv;
    logic                    r_arch;

    assign n2_p1 = (2*D)'(r1_ux) * (2*D)'(r1_vy);
    assign n2_p2 = (2*D)'(r1_uy) * (2*D)'(r1_vx);
    assign n2_s0 = (2*D)'(r1_ux) * (2*D)'(r1_ux);
    assign n2_s1 = (2*D)'(r1_uy) * (2*D)'(r1_uy);
    assign n2_s2 = (2*D)'(r1_wx) * (2*D)'(r1_wx);
    assign n2_s3 = (2*D)'(r1_wy) * (2*D)'(r1_wy);
    assign n2_s4 = (2*D)'(r1_vx) * (2*D)'(r1_vx);
    assign n2_s5 = (2*D)'(r1_vy) * (2*D)'(r1_vy);
    assign n3_cross = {r2_p1[2*D-1], r2_p1} - {r2_p2[2*D-1], r2_p2};
    assign n6_num = {{(XW-SQW){1'b0}}, r5_cross} << (FRAC_BITS + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= tpcc_pkg::THRESH_RESET;
            r1_ctl  <= '0;
            r2_ctl  <= '0;
            r3_ctl  <= '0;
            r4_ctl  <= '0;
            r5_ctl  <= '0;
            r6_ctl  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r1_ctl <= '{valid: i_start, zero: !i_has_three_points, sat: 1'b0};
            r2_ctl <= r1_ctl;
            r3_ctl <= '{valid: r2_ctl.valid, zero: r2_ctl.zero || (n3_cross == '0),
                        sat: 1'b0};
            r4_ctl <= s_ctl[RW];
            r5_ctl <= r4_ctl;
            r6_ctl <= '{valid: r5_ctl.valid, zero: r5_ctl.zero,
                        sat: n6_num >= ({{(XW-DENW){1'b0}}, r5_den} << CB)};
            r_valid <= d_ctl[CB].valid;
        end
        r1_ux <= D'($signed(i_mid_x)) - D'($signed(i_start_x));
        r1_uy <= D'($signed(i_mid_y)) - D'($signed(i_start_y));
        r1_vx <= D'($signed(i_end_x)) - D'($signed(i_start_x));
        r1_vy <= D'($signed(i_end_y)) - D'($signed(i_start_y));
        r1_wx <= D'($signed(i_end_x)) - D'($signed(i_mid_x));
        r1_wy <= D'($signed(i_end_y)) - D'($signed(i_mid_y));
        r2_p1 <= n2_p1;
        r2_p2 <= n2_p2;
        r2_sq <= {n2_s5, n2_s4, n2_s3, n2_s2, n2_s1, n2_s0};
        r3_cross <= n3_cross[SQW-1] ? SQW'(-n3_cross) : n3_cross;
        r3_sq[0] <= {1'b0, r2_sq[0]} + {1'b0, r2_sq[1]};
        r3_sq[1] <= {1'b0, r2_sq[2]} + {1'b0, r2_sq[3]};
        r3_sq[2] <= {1'b0, r2_sq[4]} + {1'b0, r2_sq[5]};
        r4_ab    <= {{RW{1'b0}}, s_root[RW][0]} * {{RW{1'b0}}, s_root[RW][1]};
        r4_c     <= s_root[RW][2];
        r4_cross <= s_tag[RW];
        r5_den   <= {{RW{1'b0}}, r4_ab} * {{(2*RW){1'b0}}, r4_c};
        r5_cross <= r4_cross;
        r6_num   <= n6_num;
        r6_den   <= r5_den;
        r_curv   <= n_curv;
        r_arch   <= n_curv < r_thr;
    end

    assign s_ctl[0]  = r3_ctl;
    assign s_rem[0]  = r3_sq;
    assign s_root[0] = '0;
    assign s_tag[0]  = r3_cross;

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        tpcc_sqrt_cell #(.SQW(SQW), .RW(RW), .TAGW(SQW), .K(RW - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (s_ctl[j]),
            .i_rem  (s_rem[j]),
            .i_root (s_root[j]),
            .i_tag  (s_tag[j]),
            .o_ctl  (s_ctl[j+1]),
            .o_rem  (s_rem[j+1]),
            .o_root (s_root[j+1]),
            .o_tag  (s_tag[j+1])
        );
    end

    assign d_ctl[0] = r6_ctl;
    assign d_rem[0] = r6_num;
    assign d_quo[0] = '0;
    assign d_den[0] = r6_den;

    for (genvar j = 0; j < CB; j++) begin : g_div
        tpcc_div_cell #(.XW(XW), .DENW(DENW), .IDX(CB - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (d_ctl[j]),
            .i_rem  (d_rem[j]),
            .i_quo  (d_quo[j]),
            .i_den  (d_den[j]),
            .o_ctl  (d_ctl[j+1]),
            .o_rem  (d_rem[j+1]),
            .o_quo  (d_quo[j+1]),
            .o_den  (d_den[j+1])
        );
    end

    // Too few points or collinear: zero; quotient past range: clamp.
    always_comb begin
        if (d_ctl[CB].zero) begin
            n_curv = '0;
        end else if (d_ctl[CB].sat) begin
            n_curv = tpcc_pkg::CURV_MAX;
        end else begin
            n_curv = d_quo[CB];
        end
    end

    assign o_busy      = 1'b0;
    assign o_valid     = r_valid;
    assign o_curvature = r_curv;
    assign o_is_arch   = r_arch;
endmodule
`default_nettype wire

// ----- src/tpcc_checker.sv -----
`default_nettype none
`include "three_point_curvature_classifier_core_defines.svh"
module tpcc_checker #(
    parameter int LAT        = 51
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_start,
    input wire                               o_busy,
    input wire                               i_has_three_points,
    input wire                               o_valid,
    input wire [tpcc_pkg::CURV_BITS-1:0]     o_curvature
);
    `TPCC_ASSERT_IMPL(a_never_busy, 1'b1, !o_busy)
    `TPCC_ASSERT_NEXT(a_reset_flush, !i_rst_n, !o_valid)
    `TPCC_ASSERT_IMPL(a_one_result, i_start && !o_busy, ##LAT o_valid)
    `TPCC_ASSERT_IMPL(a_no_extra, !i_start, ##LAT !o_valid)
    `TPCC_ASSERT_IMPL(a_two_points_zero, i_start && !i_has_three_points,
        ##LAT (o_curvature == '0))
endmodule

bind three_point_curvature_classifier_core tpcc_checker #(
    .LAT       (LAT_CYCLES)
) u_tpcc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .i_has_three_points(i_has_three_points),
    .o_valid           (o_valid),
    .o_curvature       (o_curvature)
);
`default_nettype wire
